// File: src/escw_pkg.sv
`timescale 1ns / 1ps

package escw_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_FEED = 1'b1;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd500;
  localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd2000;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] now_ms;
    logic              estop_pin_level;
    logic              motor_latched;
    logic              motor_stopped_by_watchdog;
  } in_item_t;

  typedef struct packed {
    logic              estop_active;
    logic              watchdog_tripped;
    logic [1:0]        estop_action;
    logic              watchdog_stop_order;
    logic [TIME_W-1:0] time_since_command;
    logic [TIME_W-1:0] press_count;
    logic [TIME_W-1:0] trip_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time_ms;
    logic [CFG_W-1:0] release_hold_ms;
    logic [CFG_W-1:0] command_timeout_ms;
  } cfg_regs_t;

endpackage

// File: src/escw_if.sv
`timescale 1ns / 1ps

interface escw_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] now_ms;
  logic        estop_pin_level;
  logic        motor_latched;
  logic        motor_stopped_by_watchdog;

  modport source (
    output valid, operation, now_ms, estop_pin_level, motor_latched,
           motor_stopped_by_watchdog,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, estop_pin_level, motor_latched,
           motor_stopped_by_watchdog,
    output ready
  );
endinterface

interface escw_out_if;
  logic        valid;
  logic        ready;
  logic        estop_active;
  logic        watchdog_tripped;
  logic [1:0]  estop_action;
  logic        watchdog_stop_order;
  logic [31:0] time_since_command;
  logic [31:0] press_count;
  logic [31:0] trip_count;

  modport source (
    output valid, estop_active, watchdog_tripped, estop_action, watchdog_stop_order,
           time_since_command, press_count, trip_count,
    input  ready
  );
  modport sink (
    input  valid, estop_active, watchdog_tripped, estop_action, watchdog_stop_order,
           time_since_command, press_count, trip_count,
    output ready
  );
endinterface

interface escw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/estop_debounce_command_watchdog_core.sv
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// in_ch    in   valid/ready        operation, now_ms, pin level, motor status
// out_ch   out  valid/ready        stop/trip flags, actions, time, counters
// cfg_ch   in   valid/ready        index (2b), data (16b), always ready
//
// One beat per cycle sustained while out_ch is ready. Data passes the input
// register, then the supervisor state and result register update together.
// Synchronous active-low reset: stop released, watchdog tripped, not fed,
// counters zero, registers at 50/500/2000 ms.
// A stalled output holds its beat; the input register still takes one more.

module estop_debounce_command_watchdog_core (
  input logic        clk,
  input logic        rst_n,
  escw_in_if.sink    in_ch,
  escw_out_if.source out_ch,
  escw_cfg_if.sink   cfg_ch
);
  import escw_pkg::*;

  cfg_regs_t cfg_r;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_r;
  out_item_t result;
  logic      out_valid_r;
  logic      in_fire;
  logic      out_load;

  assign out_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || out_load;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time_ms   <= DEBOUNCE_RST;
      cfg_r.release_hold_ms    <= RELEASE_RST;
      cfg_r.command_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DEBOUNCE: cfg_r.debounce_time_ms   <= cfg_ch.data;
        CFG_RELEASE:  cfg_r.release_hold_ms    <= cfg_ch.data;
        CFG_TIMEOUT:  cfg_r.command_timeout_ms <= cfg_ch.data;
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_fire || (s1_valid_r && !out_load);
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.operation                 <= in_ch.operation;
      s1_item_r.now_ms                    <= in_ch.now_ms;
      s1_item_r.estop_pin_level           <= in_ch.estop_pin_level;
      s1_item_r.motor_latched             <= in_ch.motor_latched;
      s1_item_r.motor_stopped_by_watchdog <= in_ch.motor_stopped_by_watchdog;
    end
    if (out_load) begin
      out_r <= result;
    end
  end

  escw_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (out_load),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_ch.valid               = out_valid_r;
  assign out_ch.estop_active        = out_r.estop_active;
  assign out_ch.watchdog_tripped    = out_r.watchdog_tripped;
  assign out_ch.estop_action        = out_r.estop_action;
  assign out_ch.watchdog_stop_order = out_r.watchdog_stop_order;
  assign out_ch.time_since_command  = out_r.time_since_command;
  assign out_ch.press_count         = out_r.press_count;
  assign out_ch.trip_count          = out_r.trip_count;

  a_stop_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.estop_action == ACT_STOP |-> out_r.estop_active)
    else $error("stop order without active estop");

  a_clear_implies_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.estop_action == ACT_CLEAR |-> !out_r.estop_active)
    else $error("latch clear while estop active");

  a_wd_order_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.watchdog_stop_order |->
      out_r.watchdog_tripped && !out_r.estop_active)
    else $error("watchdog stop without trip or during estop");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled with free slot");

endmodule

// File: src/escw_engine.sv
`timescale 1ns / 1ps

module escw_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  escw_pkg::in_item_t   item,
  input  escw_pkg::cfg_regs_t  cfg,
  output escw_pkg::out_item_t  result
);
  import escw_pkg::*;

  logic              pin_last_r,   pin_last_nxt;
  logic              latched_r,    latched_nxt;
  logic [TIME_W-1:0] pin_chg_r,    pin_chg_nxt;
  logic [TIME_W-1:0] release_r,    release_nxt;
  logic [TIME_W-1:0] presses_r,    presses_nxt;
  logic [TIME_W-1:0] last_feed_r,  last_feed_nxt;
  logic              fed_r,        fed_nxt;
  logic              trip_r,       trip_nxt;
  logic [TIME_W-1:0] trips_r,      trips_nxt;

  logic [TIME_W-1:0] since_chg;
  logic [TIME_W-1:0] since_rel;
  logic [TIME_W-1:0] since_feed;
  logic              deb_ok;
  logic              hold_ok;
  logic              expired;
  logic              pressed;
  logic [1:0]        action;
  logic              wd_order;

  assign since_chg  = item.now_ms - pin_chg_r;
  assign since_rel  = item.now_ms - release_r;
  assign since_feed = item.now_ms - last_feed_r;
  assign deb_ok     = since_chg >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time_ms};
  assign hold_ok    = since_rel >= {{(TIME_W-CFG_W){1'b0}}, cfg.release_hold_ms};
  assign expired    = !fed_r ||
                      since_feed >= {{(TIME_W-CFG_W){1'b0}}, cfg.command_timeout_ms};
  assign pressed    = !item.estop_pin_level;

  always_comb begin
    pin_last_nxt  = pin_last_r;
    latched_nxt   = latched_r;
    pin_chg_nxt   = pin_chg_r;
    release_nxt   = release_r;
    presses_nxt   = presses_r;
    last_feed_nxt = last_feed_r;
    fed_nxt       = fed_r;
    trip_nxt      = trip_r;
    trips_nxt     = trips_r;
    action        = ACT_NONE;
    wd_order      = 1'b0;

    if (item.operation == OP_FEED) begin
      last_feed_nxt = item.now_ms;
      fed_nxt       = 1'b1;
      trip_nxt      = 1'b0;
    end else begin
      priority if (item.estop_pin_level != pin_last_r) begin
        pin_last_nxt = item.estop_pin_level;
        pin_chg_nxt  = item.now_ms;
      end else if (!deb_ok) begin
        action = ACT_NONE;
      end else if (pressed && !latched_r) begin
        latched_nxt = 1'b1;
        presses_nxt = presses_r + 1'b1;
        action      = ACT_STOP;
      end else if (!pressed && latched_r) begin
        latched_nxt = 1'b0;
        release_nxt = item.now_ms;
      end else if (!pressed && item.motor_latched && hold_ok) begin
        action = ACT_CLEAR;
      end else begin
        action = ACT_NONE;
      end

      if (!latched_nxt && expired) begin
        if (!trip_r) begin
          trip_nxt  = 1'b1;
          trips_nxt = trips_r + 1'b1;
        end
        wd_order = !item.motor_stopped_by_watchdog;
      end
    end
  end

  always_comb begin
    result.estop_active        = latched_nxt;
    result.watchdog_tripped    = trip_nxt;
    result.estop_action        = action;
    result.watchdog_stop_order = wd_order;
    result.time_since_command  = item.now_ms - last_feed_nxt;
    result.press_count         = presses_nxt;
    result.trip_count          = trips_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_last_r  <= 1'b1;
      latched_r   <= 1'b0;
      pin_chg_r   <= '0;
      release_r   <= '0;
      presses_r   <= '0;
      last_feed_r <= '0;
      fed_r       <= 1'b0;
      trip_r      <= 1'b1;
      trips_r     <= '0;
    end else if (fire) begin
      pin_last_r  <= pin_last_nxt;
      latched_r   <= latched_nxt;
      pin_chg_r   <= pin_chg_nxt;
      release_r   <= release_nxt;
      presses_r   <= presses_nxt;
      last_feed_r <= last_feed_nxt;
      fed_r       <= fed_nxt;
      trip_r      <= trip_nxt;
      trips_r     <= trips_nxt;
    end
  end

endmodule
